/* rtl/tbu_pkg.sv */
// tbu_pkg: shared widths, character codes and register indexes for the
// two-bit base unpacker. No dependencies.
`timescale 1ns / 1ps

package tbu_pkg;

   localparam int BYTE_W     = 8;
   localparam int CHAR_W     = 8;
   localparam int TOTAL_W    = 40;
   localparam int LW_W       = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam logic [LW_W-1:0]   LW_RESET = 8'd60;
   localparam logic [LW_W-1:0]   COL_MAX  = 8'hFF;

   localparam logic [CHAR_W-1:0] CHAR_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C  = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_G  = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_T  = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_U  = 8'h55;
   localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;

   typedef enum logic [1:0] {
      CODE_A = 2'd0,
      CODE_C = 2'd1,
      CODE_G = 2'd2,
      CODE_T = 2'd3
   } base_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RNA_MODE    = 2'd0,
      CSR_TOTAL_BASES = 2'd1,
      CSR_LINE_WIDTH  = 2'd2
   } csr_idx_type;

   // ascii letter for one base code
   function automatic logic [CHAR_W-1:0] code_letter(input logic [1:0] code,
                                                     input logic       rna);
      logic [CHAR_W-1:0] ch;
      case (code)
         CODE_A:  ch = CHAR_A;
         CODE_C:  ch = CHAR_C;
         CODE_G:  ch = CHAR_G;
         default: ch = rna ? CHAR_U : CHAR_T;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/tbu_req_if.sv */
// tbu_req_if: request channel carrying one packed byte of base codes.
// Depends on tbu_pkg.
`timescale 1ns / 1ps

interface tbu_req_if import tbu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] packed_byte;

   modport source (output valid, output packed_byte, input ready);
   modport sink   (input valid, input packed_byte, output ready);
endinterface

/* rtl/tbu_rsp_if.sv */
// tbu_rsp_if: result channel carrying one output character and its flags.
// Depends on tbu_pkg.
`timescale 1ns / 1ps

interface tbu_rsp_if import tbu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last_of_run;
   logic              sequence_done;

   modport source (output valid, output out_char, output last_of_run,
                   output sequence_done, input ready);
   modport sink   (input valid, input out_char, input last_of_run,
                   input sequence_done, output ready);
endinterface

/* rtl/tbu_csr_if.sv */
// tbu_csr_if: register write channel, index plus write data.
// Depends on tbu_pkg.
`timescale 1ns / 1ps

interface tbu_csr_if import tbu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/two_bit_base_unpacker_wrap.sv */
// two_bit_base_unpacker_wrap: unpacks four 2-bit bases per request byte into
// ascii letters with newline wrapping. A request passes through the input
// register and then the result buffer before its first character is offered.
// throughput: one character per cycle on the result port while the result
// side is ready; a request yields n characters (0 to 8), typically 4 or 5.
// reset (synchronous): counters cleared, registers to defaults, buffers empty.
`timescale 1ns / 1ps

module two_bit_base_unpacker_wrap import tbu_pkg::*; #(
   parameter int COUNT_BITS = 40
) (
   input logic        clock,
   input logic        reset,
   tbu_csr_if.sink    csr_ch,
   tbu_req_if.sink    req_ch,
   tbu_rsp_if.source  rsp_ch
);

   // compare width covers both the base counter and the length register
   localparam int CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration registers
   logic                  rna_mode_ff;
   logic [TOTAL_W-1:0]    total_bases_ff;
   logic [LW_W-1:0]       line_width_ff;

   // running state
   logic [COUNT_BITS-1:0] emitted_ff, emitted_in;
   logic [LW_W-1:0]       column_ff, column_in;

   // input register
   logic                  in_valid_ff;
   logic [BYTE_W-1:0]     in_byte_ff;

   // result buffer: slot 2j is letter j, slot 2j+1 its line-end newline,
   // slot 8 the closing newline of a partial last line
   logic [8:0]            mask_ff, mask_in;
   logic [CHAR_W-1:0]     letters_ff [0:3];
   logic [CHAR_W-1:0]     letters_in [0:3];
   logic                  fin_ff, fin_in;

   logic                  rsp_fire;
   logic                  buf_single;
   logic                  buf_free;
   logic                  a_move;
   logic [3:0]            pos;

   logic [COUNT_BITS:0]   sum_j;
   logic [COUNT_BITS-1:0] e_sat [0:4];
   logic [4:0]            lt;

   // ------------------------------------------------------------------
   // configuration writes, always accepted
   // ------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rna_mode_ff    <= 1'b0;
         total_bases_ff <= '0;
         line_width_ff  <= LW_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_RNA_MODE:    rna_mode_ff    <= csr_ch.data[0];
            CSR_TOTAL_BASES: total_bases_ff <= csr_ch.data[TOTAL_W-1:0];
            CSR_LINE_WIDTH:  line_width_ff  <= csr_ch.data[LW_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // handshake control
   // ------------------------------------------------------------------
   assign rsp_fire   = rsp_ch.valid && rsp_ch.ready;
   // at most one slot left in the buffer
   assign buf_single = (mask_ff & (mask_ff - 9'd1)) == 9'd0;
   // buffer takes new results when empty or when its last slot leaves now
   assign buf_free   = (mask_ff == 9'd0) || (rsp_fire && buf_single);
   assign a_move     = in_valid_ff && buf_free;
   // input register frees up as its byte moves into the buffer
   assign req_ch.ready = !in_valid_ff || buf_free;

   // ------------------------------------------------------------------
   // per-byte expansion
   // ------------------------------------------------------------------
   always_comb begin
      // saturated counter value after j letters, and whether it is still short
      // of the sequence length; lt is monotone, falling with j
      sum_j = '0;
      for (int j = 0; j < 5; j++) begin
         sum_j    = {1'b0, emitted_ff} + (COUNT_BITS+1)'(j);
         e_sat[j] = sum_j[COUNT_BITS] ? COUNT_MAX : sum_j[COUNT_BITS-1:0];
         lt[j]    = CMP_W'(e_sat[j]) < CMP_W'(total_bases_ff);
      end

      emitted_in = emitted_ff;
      column_in  = column_ff;
      mask_in    = '0;
      fin_in     = 1'b0;
      for (int j = 0; j < 4; j++) begin
         letters_in[j] = code_letter(in_byte_ff[7-2*j -: 2], rna_mode_ff);
         if (lt[j]) begin
            mask_in[2*j] = 1'b1;
            emitted_in   = e_sat[j+1];
            fin_in       = !lt[j+1];
            if (column_in != COL_MAX) begin
               column_in = column_in + 8'd1;
            end
            // line ends once the column reaches or passes the width
            if (column_in >= line_width_ff) begin
               mask_in[2*j+1] = 1'b1;
               column_in      = '0;
            end
         end
      end
      // close a partial final line
      if (fin_in && column_in != '0) begin
         mask_in[8] = 1'b1;
         column_in  = '0;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mask_ff     <= '0;
         emitted_ff  <= '0;
         column_ff   <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
         end else if (a_move) begin
            in_valid_ff <= 1'b0;
         end

         if (a_move) begin
            mask_ff    <= mask_in;
            emitted_ff <= emitted_in;
            column_ff  <= column_in;
         end else if (rsp_fire) begin
            // drop the slot just delivered
            mask_ff <= mask_ff & (mask_ff - 9'd1);
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.packed_byte;
      end
      if (a_move) begin
         for (int j = 0; j < 4; j++) begin
            letters_ff[j] <= letters_in[j];
         end
         fin_ff <= fin_in;
      end
   end

   // ------------------------------------------------------------------
   // result port: lowest occupied slot goes out first
   // ------------------------------------------------------------------
   always_comb begin
      pos = 4'd0;
      for (int i = 8; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pos = 4'(i);
         end
      end
   end

   assign rsp_ch.valid         = mask_ff != 9'd0;
   assign rsp_ch.out_char      = (!pos[0] && !pos[3]) ? letters_ff[pos[2:1]] : CHAR_NL;
   assign rsp_ch.last_of_run   = buf_single;
   assign rsp_ch.sequence_done = buf_single && fin_ff;

`ifndef SYNTHESIS
   // the base counter never moves backward
   a_emitted_mono: assert property (@(posedge clock) disable iff (reset)
      emitted_ff >= $past(emitted_ff))
      else $error("base counter decreased");

   // new results only land in an empty or draining buffer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      a_move |-> (mask_ff == 9'd0 || (rsp_fire && buf_single)))
      else $error("result buffer overwritten");

   // end of sequence is always the end of its request
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.sequence_done) |-> rsp_ch.last_of_run)
      else $error("sequence end not on last result of request");

   // only base letters and newlines leave the block
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.out_char == CHAR_A || rsp_ch.out_char == CHAR_C ||
                        rsp_ch.out_char == CHAR_G || rsp_ch.out_char == CHAR_T ||
                        rsp_ch.out_char == CHAR_U || rsp_ch.out_char == CHAR_NL))
      else $error("illegal output character");
`endif

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for two_bit_base_unpacker_wrap, directed table then
// random phases against a cycle-free predictor.
// Depends on tbu_pkg, tbu_req_if, tbu_rsp_if, tbu_csr_if and the rtl.
`timescale 1ns / 1ps

module tb_top;
   import tbu_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 470;
   localparam int SETTLE_CYCLES = 10;   // covers the input register, the result buffer and empty requests
   localparam int NUM_DIRECTED  = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [TOTAL_W-1:0]   COUNT_MAX    = {TOTAL_W{1'b1}};

   // letter per base code; code T becomes U in rna mode
   localparam logic [CHAR_W-1:0] DNA_LETTERS [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              done;
   } text_char_type;

   typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_type;

   // one directed step: a register write or a request, optionally with typed-in results
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [BYTE_W-1:0]     b;
      logic                  typed;
      logic [3:0]            tn;
      logic [63:0]           text;   // first character in the highest used byte
      logic                  tdone;
   } dir_row_type;

   function automatic dir_row_type reg_row(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      return '{ROW_WRITE, idx, data, 8'h00, 1'b0, 4'd0, 64'd0, 1'b0};
   endfunction

   function automatic dir_row_type byte_row(logic [BYTE_W-1:0] b);
      return '{ROW_BYTE, 2'd0, 40'd0, b, 1'b0, 4'd0, 64'd0, 1'b0};
   endfunction

   function automatic dir_row_type typed_row(logic [BYTE_W-1:0] b, logic [3:0] n,
                                             logic [63:0] text, logic done);
      return '{ROW_BYTE, 2'd0, 40'd0, b, 1'b1, n, text, done};
   endfunction

   // directed walk: empty sequence, completion, rna letters, zero line width,
   // unmapped index, lowered line width, total lowered below what was emitted
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      typed_row(8'hE4, 4'd0, 64'd0, 1'b0),                         // total 0 after reset
      reg_row(CSR_TOTAL_BASES, 40'd4),
      typed_row(8'h1B, 4'd5, {CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_NL}, 1'b1),
      typed_row(8'h00, 4'd0, 64'd0, 1'b0),                         // sequence complete
      reg_row(CSR_RNA_MODE, '1),                                   // upper bits ignored
      reg_row(CSR_TOTAL_BASES, 40'd8),
      typed_row(8'hFF, 4'd5, {CHAR_U, CHAR_U, CHAR_U, CHAR_U, CHAR_NL}, 1'b1),
      reg_row(CSR_LINE_WIDTH, 40'hAB_CDEF_0100),                   // width 0, junk above
      reg_row(CSR_RNA_MODE, 40'h2),
      reg_row(CSR_TOTAL_BASES, 40'd13),
      typed_row(8'hFF, 4'd8, {CHAR_T, CHAR_NL, CHAR_T, CHAR_NL,
                              CHAR_T, CHAR_NL, CHAR_T, CHAR_NL}, 1'b0),
      typed_row(8'h55, 4'd2, {CHAR_C, CHAR_NL}, 1'b1),             // stops mid-byte
      reg_row(CSR_UNMAPPED, '1),
      reg_row(CSR_LINE_WIDTH, 40'd3),
      reg_row(CSR_TOTAL_BASES, COUNT_MAX),
      typed_row(8'h00, 4'd5, {CHAR_A, CHAR_A, CHAR_A, CHAR_NL, CHAR_A}, 1'b0),
      byte_row(8'h9C),
      byte_row(8'h27),
      reg_row(CSR_LINE_WIDTH, 40'd10),
      byte_row(8'h6B),
      byte_row(8'hD2),
      reg_row(CSR_LINE_WIDTH, 40'd2),                              // lowered mid-line
      byte_row(8'h3C),
      reg_row(CSR_LINE_WIDTH, 40'd255),
      byte_row(8'hA5),
      byte_row(8'h5A),
      byte_row(8'hC3),
      reg_row(CSR_TOTAL_BASES, 40'd5),                             // below bases emitted
      typed_row(8'hFF, 4'd0, 64'd0, 1'b0),
      reg_row(CSR_RNA_MODE, 40'd1)
   };

   logic clock;
   logic reset;

   tbu_req_if req_ch ();
   tbu_rsp_if rsp_ch ();
   tbu_csr_if csr_ch ();

   two_bit_base_unpacker_wrap dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state and register shadow
   logic                 rna_cfg;
   logic [TOTAL_W-1:0]   total_cfg;
   logic [LW_W-1:0]      width_cfg;
   logic [TOTAL_W-1:0]   bases_done;
   logic [LW_W-1:0]      column;

   text_char_type expected_chars [$];
   int            mismatches  = 0;
   int            cycle_count = 0;
   logic          calm;   // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_pct();
      return calm ? 0 : 30;
   endfunction

   // characters one request byte should produce, updating the predictor state
   function automatic void unpack_byte(input logic [BYTE_W-1:0] b,
                                       output text_char_type res [8], output int n);
      logic       finished;
      logic [1:0] code;
      n = 0;
      finished = 1'b0;
      for (int k = 0; k < 8; k++) res[k] = '0;
      if (bases_done >= total_cfg) return;
      for (int slot = 0; slot < 4; slot++) begin
         if (bases_done >= total_cfg) break;
         code = 2'(b >> (6 - 2 * slot));
         res[n].ch = (code == CODE_T && rna_cfg) ? CHAR_U : DNA_LETTERS[code];
         n++;
         if (bases_done != COUNT_MAX) bases_done++;
         if (column != COL_MAX) column++;
         // line ends once the column reaches or passes the width
         if (column >= width_cfg) begin
            res[n].ch = CHAR_NL;
            n++;
            column = '0;
         end
         if (bases_done >= total_cfg) finished = 1'b1;
      end
      // partial last line gets its closing newline
      if (finished && column != 0) begin
         res[n].ch = CHAR_NL;
         n++;
         column = '0;
      end
      if (n > 0) begin
         res[n-1].last = 1'b1;
         res[n-1].done = finished;
      end
   endfunction

   // send one request, predicting its characters at the accepting edge
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic typed, input logic [3:0] tn,
                            input logic [63:0] text, input logic tdone, output int n);
      text_char_type res [8];
      while ($urandom_range(0, 99) < idle_pct()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.packed_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      unpack_byte(b, res, n);
      // typed-in rows override the prediction; the predictor state still advances
      if (typed) begin
         n = tn;
         for (int k = 0; k < n; k++) begin
            res[k].ch   = text[8*(n-1-k) +: 8];
            res[k].last = (k == n - 1);
            res[k].done = tdone && (k == n - 1);
         end
      end
      for (int k = 0; k < n; k++) expected_chars.push_back(res[k]);
   endtask

   // register writes only once the block is idle
   task automatic drain_and_wait();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (csr_idx_type'(idx))
         CSR_RNA_MODE:    rna_cfg   = data[0];
         CSR_TOTAL_BASES: total_cfg = data[TOTAL_W-1:0];
         CSR_LINE_WIDTH:  width_cfg = data[LW_W-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stalls
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct());
   end

   // compare every accepted character with the oldest expectation
   always @(posedge clock) begin
      text_char_type got;
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.out_char, rsp_ch.last_of_run, rsp_ch.sequence_done};
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected character %02h last=%b done=%b", got.ch, got.last, got.done);
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("expected %02h last=%b done=%b, got %02h last=%b done=%b",
                           want.ch, want.last, want.done, got.ch, got.last, got.done);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int                  n;
      int                  made;
      int                  phase;
      int                  nbytes;
      logic                long_line;
      logic [LW_W-1:0]     width_pick;
      logic [TOTAL_W-1:0]  total_pick;

      // every input known from time zero
      reset              = 1'b1;
      calm               = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.packed_byte = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = '0;
      csr_ch.data        = '0;

      // shadow of the reset state
      rna_cfg    = 1'b0;
      total_cfg  = '0;
      width_cfg  = LW_RESET;
      bases_done = '0;
      column     = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (DIRECTED[i].kind == ROW_WRITE) begin
            drain_and_wait();
            write_reg(DIRECTED[i].idx, DIRECTED[i].data);
         end else begin
            push_byte(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].tn,
                      DIRECTED[i].text, DIRECTED[i].tdone, n);
         end
      end

      // random phases: new settings, then a burst of requests
      made  = 0;
      phase = 0;
      while (made < RANDOM_ITEMS) begin
         phase++;
         drain_and_wait();
         calm      = (phase % 6 == 3);          // a stretch with no idling at all
         long_line = (phase % 10 == 5);         // full 255-letter lines, column at its max

         if (long_line || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 7))
               0:       width_pick = 8'd0;
               1:       width_pick = 8'd1;
               2:       width_pick = 8'd2;
               3:       width_pick = 8'($urandom_range(3, 20));
               4:       width_pick = LW_RESET;
               5:       width_pick = 8'($urandom_range(100, 254));
               6:       width_pick = COL_MAX;
               default: width_pick = 8'($urandom_range(0, 255));
            endcase
            if (long_line) width_pick = COL_MAX;
            write_reg(CSR_LINE_WIDTH, {$urandom(), width_pick});
         end
         if ($urandom_range(0, 1) != 0)
            write_reg(CSR_RNA_MODE, {$urandom(), 8'($urandom())});
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_UNMAPPED, {$urandom(), 8'($urandom())});

         // mostly a sequence end a few bytes ahead so completion is exercised often
         case ($urandom_range(0, 9))
            0:       total_pick = (bases_done >= 8) ? bases_done - 40'($urandom_range(0, 7))
                                                    : bases_done;
            1:       total_pick = COUNT_MAX;
            2:       total_pick = {$urandom(), 8'($urandom())};
            default: total_pick = bases_done + 40'($urandom_range(1, 60));
         endcase
         if (long_line) total_pick = COUNT_MAX;
         write_reg(CSR_TOTAL_BASES, total_pick);

         nbytes = long_line ? 70 : $urandom_range(2, 24);
         for (int i = 0; i < nbytes; i++) begin
            push_byte(8'($urandom()), 1'b0, 4'd0, 64'd0, 1'b0, n);
            made++;   // every request counts, ignored ones too
         end
      end

      // drain, then give the block time to show anything extra
      calm = 1'b0;
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
